/* rtl/mkd_pkg.sv */
// shared types and codes of the multi-key debouncer
package mkd_pkg;

   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned LEVELS_W = 8;
   localparam int unsigned KEY_W    = 3;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [OPCODE_W-1:0] OP_TICK         = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INIT         = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_TAKE_PRESS   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TAKE_RELEASE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_QUERY        = 3'd4;

   localparam logic REG_DEBOUNCE_TICKS = 1'b0;
   localparam logic REG_ACTIVE_LEVELS  = 1'b1;

   localparam logic [COUNT_W-1:0]  DEBOUNCE_RESET = 8'd20;
   localparam logic [LEVELS_W-1:0] ACTIVE_RESET   = 8'd0;

   // per-lane command for one transaction
   typedef struct packed {
      logic tick;
      logic init;
      logic take_press;
      logic take_release;
   } lane_cmd_type;

   // what a lane reports to the merge stage
   typedef struct packed {
      logic pressed;
      logic pressed_next;
      logic press_latch;
      logic release_latch;
   } lane_status_type;

   // which answer the merge stage picks
   typedef struct packed {
      logic take_press;
      logic take_release;
      logic query;
   } answer_sel_type;

endpackage

/* rtl/mkd_ifs.sv */
// valid/ready channel interfaces of the multi-key debouncer

interface mkd_req_if;
   logic                          valid;
   logic                          ready;
   logic [mkd_pkg::OPCODE_W-1:0]  opcode;
   logic [mkd_pkg::LEVELS_W-1:0]  raw_levels;
   logic [mkd_pkg::KEY_W-1:0]     key_index;

   modport source (output valid, output opcode, output raw_levels, output key_index,
                   input ready);
   modport sink   (input valid, input opcode, input raw_levels, input key_index,
                   output ready);
endinterface

interface mkd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          answer;
   logic [mkd_pkg::LEVELS_W-1:0]  pressed_flags;

   modport source (output valid, output answer, output pressed_flags, input ready);
   modport sink   (input valid, input answer, input pressed_flags, output ready);
endinterface

/* rtl/multi_key_debouncer_events.sv */
// top level of the multi-key debouncer with latched press and release events
//
// usage: transactions arrive on req_chan (opcode, raw_levels, key_index) and
// each produces exactly one transaction on rsp_chan (answer, pressed_flags).
// opcodes: tick feeds raw pin levels to every key, init loads them as stable
// and clears counters and events, take press / take release return and clear
// the addressed key's event latch, query returns its pressed flag.
// the response is registered and presented in the cycle after the request is accepted.
// throughput: one transaction per cycle while rsp_chan takes each response; the lanes
// and the merge stage sit between the request handshake and a single response register.
// stall: while rsp_chan is held off the response register keeps its contents
// and req_chan.ready drops; it rises again in the cycle the response is taken.
// reset (synchronous, active high) clears all key state and event latches,
// empties the response register and restores debounce_ticks to 20 and
// active_levels to 0.
// csr: debounce_ticks at byte address 0, active_levels at byte address 4,
// written in the access phase of an apb-style write; pready is always high.
module multi_key_debouncer_events #(
   parameter int unsigned NUM_KEYS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   mkd_req_if.sink                           req_chan,
   mkd_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mkd_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [mkd_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [mkd_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned IDX_W = $clog2(NUM_KEYS + 1) + mkd_pkg::KEY_W;

   // configuration registers
   logic [mkd_pkg::COUNT_W-1:0]   debounce_ff, debounce_in;
   logic [mkd_pkg::LEVELS_W-1:0]  active_ff, active_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          answer_ff, answer_in;
   logic [mkd_pkg::LEVELS_W-1:0]  flags_ff, flags_in;

   logic                          accept;
   logic                          csr_write;
   logic                          is_tick, is_init, is_take_press, is_take_release, is_query;
   mkd_pkg::answer_sel_type                  sel;
   mkd_pkg::lane_status_type [NUM_KEYS-1:0]  status;
   logic                          merge_answer;
   logic [mkd_pkg::LEVELS_W-1:0]  merge_flags;

   // --- configuration port ---
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      debounce_in = debounce_ff;
      active_in   = active_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            mkd_pkg::REG_DEBOUNCE_TICKS: debounce_in = csr_pwdata[mkd_pkg::COUNT_W-1:0];
            mkd_pkg::REG_ACTIVE_LEVELS:  active_in   = csr_pwdata[mkd_pkg::LEVELS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mkd_pkg::REG_DEBOUNCE_TICKS:
            csr_prdata = {{(mkd_pkg::CSR_DW - mkd_pkg::COUNT_W){1'b0}}, debounce_ff};
         mkd_pkg::REG_ACTIVE_LEVELS:
            csr_prdata = {{(mkd_pkg::CSR_DW - mkd_pkg::LEVELS_W){1'b0}}, active_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // --- request handshake: take a new transaction whenever the response slot frees ---
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   // opcode decode; unused opcodes select nothing and answer zero
   always_comb begin
      is_tick         = 1'b0;
      is_init         = 1'b0;
      is_take_press   = 1'b0;
      is_take_release = 1'b0;
      is_query        = 1'b0;
      unique case (req_chan.opcode)
         mkd_pkg::OP_TICK:         is_tick         = 1'b1;
         mkd_pkg::OP_INIT:         is_init         = 1'b1;
         mkd_pkg::OP_TAKE_PRESS:   is_take_press   = 1'b1;
         mkd_pkg::OP_TAKE_RELEASE: is_take_release = 1'b1;
         mkd_pkg::OP_QUERY:        is_query        = 1'b1;
         default: ;
      endcase
   end

   assign sel.take_press   = is_take_press;
   assign sel.take_release = is_take_release;
   assign sel.query        = is_query;

   // --- one lane per key ---
   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
      mkd_pkg::lane_cmd_type cmd;
      logic                  raw_bit;
      logic                  active_bit;
      logic                  addressed;

      // a key index at or above NUM_KEYS matches no lane, so it changes nothing
      assign addressed = ({{(IDX_W - mkd_pkg::KEY_W){1'b0}}, req_chan.key_index}
                          == IDX_W'(g));

      assign cmd.tick         = accept & is_tick;
      assign cmd.init         = accept & is_init;
      assign cmd.take_press   = accept & is_take_press & addressed;
      assign cmd.take_release = accept & is_take_release & addressed;

      // keys beyond the eighth see level zero on the pin and as active level
      if (g < mkd_pkg::LEVELS_W) begin : g_pin
         assign raw_bit    = req_chan.raw_levels[g];
         assign active_bit = active_ff[g];
      end else begin : g_nopin
         assign raw_bit    = 1'b0;
         assign active_bit = 1'b0;
      end

      mkd_key_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .pin_level      (raw_bit),
         .press_level    (active_bit),
         .debounce_ticks (debounce_ff),
         .status         (status[g])
      );
   end

   // --- merge of the lane results ---
   mkd_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .status        (status),
      .sel           (sel),
      .key_index     (req_chan.key_index),
      .answer        (merge_answer),
      .pressed_flags (merge_flags)
   );

   // --- response register ---
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      answer_in    = answer_ff;
      flags_in     = flags_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         answer_in    = merge_answer;
         flags_in     = merge_flags;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         debounce_ff  <= mkd_pkg::DEBOUNCE_RESET;
         active_ff    <= mkd_pkg::ACTIVE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         debounce_ff  <= debounce_in;
         active_ff    <= active_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      answer_ff <= answer_in;
      flags_ff  <= flags_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.answer        = answer_ff;
   assign rsp_chan.pressed_flags = flags_ff;

endmodule

/* rtl/mkd_key_lane.sv */
// debounce lane for one key: settle counter, stable level, pressed flag, event latches
module mkd_key_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  mkd_pkg::lane_cmd_type         cmd,
   input  logic                          pin_level,
   input  logic                          press_level,
   input  logic [mkd_pkg::COUNT_W-1:0]   debounce_ticks,
   output mkd_pkg::lane_status_type      status
);

   logic                          last_ff, last_in;
   logic                          stable_ff, stable_in;
   logic [mkd_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          pressed_ff, pressed_in;
   logic                          press_ff, press_in;
   logic                          release_ff, release_in;

   always_comb begin
      last_in    = last_ff;
      stable_in  = stable_ff;
      count_in   = count_ff;
      pressed_in = pressed_ff;
      press_in   = press_ff;
      release_in = release_ff;
      if (cmd.tick) begin
         if (pin_level != last_ff) begin
            last_in  = pin_level;
            count_in = '0;
         end else if (count_ff < debounce_ticks) begin
            count_in = count_ff + 1'b1;
         end else if (pin_level != stable_ff) begin
            stable_in  = pin_level;
            pressed_in = (pin_level == press_level);
            if (pin_level == press_level) begin
               press_in = 1'b1;
            end else begin
               release_in = 1'b1;
            end
         end
      end else if (cmd.init) begin
         last_in    = pin_level;
         stable_in  = pin_level;
         count_in   = '0;
         pressed_in = (pin_level == press_level);
         press_in   = 1'b0;
         release_in = 1'b0;
      end else begin
         if (cmd.take_press) begin
            press_in = 1'b0;
         end
         if (cmd.take_release) begin
            release_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= 1'b0;
         stable_ff  <= 1'b0;
         count_ff   <= '0;
         pressed_ff <= 1'b0;
         press_ff   <= 1'b0;
         release_ff <= 1'b0;
      end else begin
         last_ff    <= last_in;
         stable_ff  <= stable_in;
         count_ff   <= count_in;
         pressed_ff <= pressed_in;
         press_ff   <= press_in;
         release_ff <= release_in;
      end
   end

   assign status.pressed       = pressed_ff;
   assign status.pressed_next  = pressed_in;
   assign status.press_latch   = press_ff;
   assign status.release_latch = release_ff;

endmodule

/* rtl/mkd_merge.sv */
// merge stage: picks the addressed key's answer and gathers the pressed flags
module mkd_merge #(
   parameter int unsigned NUM_KEYS = 8
) (
   input  mkd_pkg::lane_status_type [NUM_KEYS-1:0] status,
   input  mkd_pkg::answer_sel_type                 sel,
   input  logic [mkd_pkg::KEY_W-1:0]               key_index,
   output logic                                    answer,
   output logic [mkd_pkg::LEVELS_W-1:0]            pressed_flags
);

   localparam int unsigned IDX_W = $clog2(NUM_KEYS + 1) + mkd_pkg::KEY_W;

   always_comb begin
      answer = 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if ({{(IDX_W - mkd_pkg::KEY_W){1'b0}}, key_index} == IDX_W'(i)) begin
            answer = (sel.take_press   & status[i].press_latch)
                   | (sel.take_release & status[i].release_latch)
                   | (sel.query        & status[i].pressed);
         end
      end
   end

   // keys beyond the eighth never show up in the flags
   for (genvar g = 0; g < mkd_pkg::LEVELS_W; g++) begin : g_flags
      if (g < NUM_KEYS) begin : g_used
         assign pressed_flags[g] = status[g].pressed_next;
      end else begin : g_unused
         assign pressed_flags[g] = 1'b0;
      end
   end

endmodule
